/* rtl/i2c_master_write_sequencer_core_macros.svh */
// ----------------------------------------------------------------------------
// I2C master write sequencer assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_WRITE_SEQUENCER_CORE_MACROS_SVH
`define I2C_MASTER_WRITE_SEQUENCER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define I2CW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/i2cw_pkg.sv */
// ----------------------------------------------------------------------------
// I2C master write sequencer package
// Command codes, the queued command record and queue sizing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cw_pkg;

    // Request codes as they arrive on req_type; the fourth code is ignored.
    localparam logic [1:0] KIND_BEGIN = 2'd0;
    localparam logic [1:0] KIND_DATA  = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Bit index of the acknowledge clock inside a byte.
    localparam logic [3:0] ACK_BIT = 4'd8;

    // Step codes inside one bit slot: data set-up, clock high, clock low.
    localparam logic [1:0] SLOT_SDA = 2'd0;
    localparam logic [1:0] SLOT_HI  = 2'd1;
    localparam logic [1:0] SLOT_LO  = 2'd2;

    // Step codes of the start prefix and of the stop sequence.
    localparam logic [1:0] SEQ_0 = 2'd0;
    localparam logic [1:0] SEQ_1 = 2'd1;
    localparam logic [1:0] SEQ_2 = 2'd2;
    localparam logic [1:0] SEQ_3 = 2'd3;

    // Command queue between front and back.
    localparam int QDEPTH = 2;
    localparam int QAW    = 1;
    localparam int QCW    = 2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] payload;  // address with write bit, or data byte
        logic       ack;      // SDA level at the acknowledge clock
    } cmd_t;

endpackage

`default_nettype wire

/* rtl/i2cw_front.sv */
// ----------------------------------------------------------------------------
// I2C write sequencer front end
// Accepts request beats, drops the unused code and forms queue commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cw_front
    import i2cw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] req_type,
    input  wire logic [6:0] slave_addr,
    input  wire logic [7:0] data_byte,
    input  wire logic       ack_level,
    output logic            push,
    output cmd_t            push_cmd,
    input  wire logic       q_full
);

    logic valid_reg;
    logic valid_next;
    cmd_t cmd_reg;
    cmd_t cmd_next;

    // Holding register stalls only while its command cannot enter the queue.
    assign in_stall = valid_reg && q_full;
    assign push     = valid_reg && !q_full;
    assign push_cmd = cmd_reg;

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next   = cmd_reg;
        if (!in_stall)
        begin
            valid_next       = in_valid && (req_type != KIND_NONE);
            cmd_next.kind    = req_type;
            cmd_next.ack     = ack_level;
            cmd_next.payload = (req_type == KIND_BEGIN) ? {slave_addr, 1'b0} : data_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

`default_nettype wire

/* rtl/i2cw_queue.sv */
// ----------------------------------------------------------------------------
// I2C write sequencer command queue
// Small first-in first-out buffer that decouples front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_write_sequencer_core_macros.svh"

module i2cw_queue
    import i2cw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output logic      q_full,
    output logic      q_valid,
    output cmd_t      q_cmd
);

    cmd_t             mem [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QCW-1:0]   count_reg;
    logic [QCW-1:0]   count_next;

    assign q_full  = (count_reg == QCW'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `I2CW_ASSERT_NOW(a_no_overflow, push, !q_full, "command pushed into a full queue")
    `I2CW_ASSERT_NOW(a_no_underflow, pop, q_valid, "command popped from an empty queue")
    `I2CW_ASSERT_NOW(a_count_range, 1'b1, count_reg <= QCW'(QDEPTH), "queue count out of range")

endmodule

`default_nettype wire

/* rtl/i2cw_back.sv */
// ----------------------------------------------------------------------------
// I2C write sequencer line stepper
// Walks one command through its SCL/SDA steps into an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_write_sequencer_core_macros.svh"

module i2cw_back
    import i2cw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic q_valid,
    input  wire cmd_t q_cmd,
    output logic      pop,
    output logic      out_valid,
    input  wire logic out_stall,
    output logic      scl_level,
    output logic      sda_level,
    output logic      sample_point,
    output logic      byte_acked,
    output logic      transfer_ok,
    output logic      last_step
);

    logic       busy_reg,   busy_next;
    logic [1:0] kind_reg,   kind_next;
    logic [7:0] shift_reg,  shift_next;
    logic       ack_reg,    ack_next;
    logic       pfx_reg,    pfx_next;
    logic [1:0] cnt_reg,    cnt_next;
    logic [3:0] bit_reg,    bit_next;
    logic       scl_reg,    scl_next;
    logic       sda_reg,    sda_next;
    logic       all_ok_reg, all_ok_next;
    logic       ov_reg,     ov_next;
    logic       smp_reg,    smp_next;
    logic       bak_reg,    bak_next;
    logic       tok_reg,    tok_next;
    logic       last_reg,   last_next;
    logic       step_go;

    assign pop     = !busy_reg && q_valid;
    assign step_go = busy_reg && (!ov_reg || !out_stall);

    assign out_valid    = ov_reg;
    assign scl_level    = scl_reg;
    assign sda_level    = sda_reg;
    assign sample_point = smp_reg;
    assign byte_acked   = bak_reg;
    assign transfer_ok  = tok_reg;
    assign last_step    = last_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        kind_next   = kind_reg;
        shift_next  = shift_reg;
        ack_next    = ack_reg;
        pfx_next    = pfx_reg;
        cnt_next    = cnt_reg;
        bit_next    = bit_reg;
        scl_next    = scl_reg;
        sda_next    = sda_reg;
        all_ok_next = all_ok_reg;
        ov_next     = ov_reg && out_stall;
        smp_next    = smp_reg;
        bak_next    = bak_reg;
        tok_next    = tok_reg;
        last_next   = last_reg;

        if (pop)
        begin
            busy_next  = 1'b1;
            kind_next  = q_cmd.kind;
            shift_next = q_cmd.payload;
            ack_next   = q_cmd.ack;
            pfx_next   = (q_cmd.kind == KIND_BEGIN);
            cnt_next   = SEQ_0;
            bit_next   = '0;
        end
        else if (step_go)
        begin
            ov_next   = 1'b1;
            smp_next  = 1'b0;
            last_next = 1'b0;
            cnt_next  = cnt_reg + 2'd1;
            if (kind_reg == KIND_END)
            begin
                case (cnt_reg)
                    SEQ_0:   scl_next = 1'b0;
                    SEQ_1:   sda_next = 1'b0;
                    SEQ_2:   scl_next = 1'b1;
                    default:
                    begin
                        sda_next  = 1'b1;
                        last_next = 1'b1;
                    end
                endcase
            end
            else if (pfx_reg)
            begin
                case (cnt_reg)
                    SEQ_0:   sda_next = 1'b1;
                    SEQ_1:   scl_next = 1'b1;
                    SEQ_2:   sda_next = 1'b0;
                    default:
                    begin
                        scl_next = 1'b0;
                        pfx_next = 1'b0;
                    end
                endcase
            end
            else
            begin
                case (cnt_reg)
                    SLOT_SDA: sda_next = (bit_reg == ACK_BIT) ? 1'b1 : shift_reg[7];
                    SLOT_HI:
                    begin
                        scl_next = 1'b1;
                        smp_next = (bit_reg == ACK_BIT);
                    end
                    default:
                    begin
                        scl_next   = 1'b0;
                        cnt_next   = SLOT_SDA;
                        shift_next = {shift_reg[6:0], 1'b0};
                        bit_next   = bit_reg + 4'd1;
                        last_next  = (bit_reg == ACK_BIT);
                    end
                endcase
            end

            // Results reported on the closing step of the command.
            bak_next = last_next && (kind_reg != KIND_END) && !ack_reg;
            tok_next = last_next && (kind_reg == KIND_END) && all_ok_reg;
            if (last_next)
            begin
                busy_next = 1'b0;
                if (kind_reg == KIND_BEGIN)
                begin
                    all_ok_next = !ack_reg;
                end
                else if (kind_reg == KIND_DATA)
                begin
                    all_ok_next = all_ok_reg && !ack_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            ov_reg     <= 1'b0;
            scl_reg    <= 1'b1;
            sda_reg    <= 1'b1;
            all_ok_reg <= 1'b1;
        end
        else
        begin
            busy_reg   <= busy_next;
            ov_reg     <= ov_next;
            scl_reg    <= scl_next;
            sda_reg    <= sda_next;
            all_ok_reg <= all_ok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        shift_reg <= shift_next;
        ack_reg   <= ack_next;
        pfx_reg   <= pfx_next;
        cnt_reg   <= cnt_next;
        bit_reg   <= bit_next;
        smp_reg   <= smp_next;
        bak_reg   <= bak_next;
        tok_reg   <= tok_next;
        last_reg  <= last_next;
    end

    `I2CW_ASSERT_NOW(a_sample_lines, ov_reg && smp_reg, scl_reg && sda_reg, "ack sample lines")
    `I2CW_ASSERT_NOW(a_last_lines, ov_reg && last_reg, !scl_reg || sda_reg, "wrong end line state")
    `I2CW_ASSERT_NEXT(a_step_shown, step_go, ov_reg, "line step not presented")

endmodule

`default_nettype wire

/* rtl/i2c_master_write_sequencer_core.sv */
// Path: a request beat is registered in the front end, written into the queue and
// loaded into the stepper when it is free, which then registers its first line step.
// Throughput: one line step per cycle while out_stall is low; begin is 31 steps, data
// 27 and end 4, each loaded into the single line stepper once it is no longer busy.
// Reset (rst_n low, asynchronous): SCL and SDA idle high, acknowledge flag set,
// queue and output register empty.
// ----------------------------------------------------------------------------
// I2C master write sequencer core
// Turns begin, data and end commands into SCL/SDA line steps, one output
// beat per step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_write_sequencer_core
    import i2cw_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    // Command channel.
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] req_type,
    input  wire logic [6:0] slave_addr,
    input  wire logic [7:0] data_byte,
    input  wire logic       ack_level,
    // Line step channel.
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic            scl_level,
    output logic            sda_level,
    output logic            sample_point,
    output logic            byte_acked,
    output logic            transfer_ok,
    output logic            last_step
);

    // The front end registers each beat, folds the address and write bit into
    // one payload byte and discards the unused request code. A two-entry queue
    // lets new commands arrive while the stepper still drives an earlier one.
    cmd_t push_cmd;
    cmd_t q_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;

    i2cw_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .req_type   (req_type),
        .slave_addr (slave_addr),
        .data_byte  (data_byte),
        .ack_level  (ack_level),
        .push       (push),
        .push_cmd   (push_cmd),
        .q_full     (q_full)
    );

    i2cw_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .q_full   (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd)
    );

    // The stepper holds the persistent line levels and the running acknowledge
    // flag; every line assignment becomes one output beat, even when a level
    // does not change.
    i2cw_back u_back
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_cmd        (q_cmd),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .scl_level    (scl_level),
        .sda_level    (sda_level),
        .sample_point (sample_point),
        .byte_acked   (byte_acked),
        .transfer_ok  (transfer_ok),
        .last_step    (last_step)
    );

endmodule

`default_nettype wire
